FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAX_ORDER_DEF = 10;
	localparam int ORD_W         = 4;
	localparam int LSL_W         = 5;
	localparam int ADDR_W        = 48;
	localparam int SIZE_W        = 32;
	localparam int STAT_W        = 2;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd2;

	localparam logic [LSL_W-1:0]  LSL_RST   = 5'd4;
	localparam logic [ORD_W-1:0]  MAXO_RST  = 4'd10;
	localparam logic [ADDR_W-1:0] BASE_RST  = 48'h0000_4000_0000;

	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISP,
		S_A_SCAN, S_A_POP, S_SPLIT, S_SPLIT_WR, S_GRANT, S_OOM,
		S_NULL, S_BAD,
		S_F_SUB, S_F_CHK, S_F_VAL, S_MERGE, S_BCHK, S_WALK, S_WCHK, S_PUSH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_SWEEP, OP_CAPTURE,
		OP_SCAN_INC, OP_A_READ, OP_A_POP, OP_SPLIT_DEC, OP_SPLIT_WR, OP_A_GRANT,
		OP_OOM, OP_BAD, OP_NULL,
		OP_F_SUB, OP_F_READ, OP_F_CLAIM, OP_B_READ, OP_UNLINK_HEAD,
		OP_WALK_START, OP_WALK_READ, OP_WALK_NEXT, OP_WALK_LINK, OP_PUSH
	} dp_op_t;

	typedef struct packed {
		logic cfg_hit;
		logic sweep_last;
		logic is_free;
		logic null_free;
		logic fit_cur;
		logic fit_low;
		logic head_end;
		logic at_top;
		logic range_bad;
		logic entry_ok;
		logic buddy_free;
		logic head_is_buddy;
		logic walk_stop;
		logic link_hit;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: sv/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Leaf table memory, free-list heads, config registers and result word.
// ----------------------------------------------------------------------------
module bba_datapath #(
	parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                           opcode,
	input  logic [bba_pkg::SIZE_W-1:0]     request_size,
	input  logic [bba_pkg::ADDR_W-1:0]     free_address,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [bba_pkg::STAT_W-1:0]     status,
	output logic [bba_pkg::ADDR_W-1:0]     block_address,
	output logic [bba_pkg::ORD_W-1:0]      block_order,
	input  bba_pkg::dp_op_t                op,
	output bba_pkg::dp_stat_t              stat
);
	import bba_pkg::*;

	localparam int IW  = (MAX_ORDER > 0) ? MAX_ORDER : 1;
	localparam int NW  = IW + 1;
	localparam int TBL = 1 << MAX_ORDER;
	localparam int HN  = MAX_ORDER + 1;
	localparam int HIW = (HN > 1) ? $clog2(HN) : 1;
	localparam int EW  = NW + ORD_W;
	localparam logic [NW-1:0] END_MARK  = {NW{1'b1}};
	localparam logic [NW-1:0] BUSY_MARK = {{IW{1'b1}}, 1'b0};

	logic [EW-1:0]     mem [TBL];
	logic [EW-1:0]     rd_q;
	logic [NW-1:0]     heads_q [HN];

	logic [LSL_W-1:0]  lsl_q;
	logic [ORD_W-1:0]  maxo_q;
	logic [ADDR_W-1:0] base_q;
	logic              full_q;
	logic [IW-1:0]     sweep_q;
	logic              out_valid_q;

	logic              opc_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [ADDR_W-1:0] offset_q;
	logic [ORD_W-1:0]  ord_q;
	logic [IW-1:0]     off_q;
	logic [IW-1:0]     local_q;
	logic [IW-1:0]     buddy_q;
	logic [IW-1:0]     cidx_q;
	logic [NW-1:0]     cur_q;
	logic [NW-1:0]     bnext_q;
	logic [IW:0]       steps_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [ORD_W-1:0]  res_ord_q;

	logic [ORD_W-1:0]  m_eff;
	logic [HIW-1:0]    hsel;
	logic [NW-1:0]     head_cur;
	logic [NW-1:0]     rd_next;
	logic [ORD_W-1:0]  rd_order;
	logic [IW-1:0]     ord_bit;
	logic [IW-1:0]     local_calc;
	logic [ADDR_W-1:0] grant_addr;
	logic [LSL_W:0]    shamt;
	logic              sweep_last;
	logic              res_load;
	logic              cfg_hit;

	logic              mem_we;
	logic              mem_re;
	logic [IW-1:0]     mem_waddr;
	logic [IW-1:0]     mem_raddr;
	logic [EW-1:0]     mem_wdata;

	function automatic logic fits(input logic [LSL_W-1:0] l, input logic [ORD_W-1:0] o,
			input logic [SIZE_W-1:0] sz);
		logic [LSL_W:0] k;
		k = (LSL_W+1)'(l) + (LSL_W+1)'(o);
		return (k >= (LSL_W+1)'(SIZE_W)) || ({1'b0, sz} <= ((SIZE_W+1)'(1) << k));
	endfunction

	assign m_eff      = (maxo_q > MAX_ORDER) ? ORD_W'(MAX_ORDER) : maxo_q;
	assign hsel       = HIW'(ord_q);
	assign head_cur   = heads_q[hsel];
	assign rd_next    = rd_q[EW-1:ORD_W];
	assign rd_order   = rd_q[ORD_W-1:0];
	assign ord_bit    = IW'(1) << ord_q;
	assign local_calc = IW'(offset_q >> lsl_q);
	assign grant_addr = base_q + (ADDR_W'(off_q) << lsl_q);
	assign shamt      = (LSL_W+1)'(lsl_q) + (LSL_W+1)'(m_eff);
	assign sweep_last = (sweep_q == (full_q ? IW'(TBL - 1) : '0));
	assign cfg_hit    = cfg_valid && (cfg_index == CFG_LEAF_LOG2 ||
		cfg_index == CFG_MAX_ORDER || cfg_index == CFG_POOL_BASE);
	assign res_load   = (op == OP_A_GRANT) || (op == OP_OOM) || (op == OP_BAD) ||
		(op == OP_NULL) || (op == OP_PUSH);

	always_comb begin
		stat.cfg_hit       = cfg_hit;
		stat.sweep_last    = sweep_last;
		stat.is_free       = (opc_q == OPC_FREE);
		stat.null_free     = (faddr_q == '0);
		stat.fit_cur       = fits(lsl_q, ord_q, size_q);
		stat.fit_low       = (ord_q != '0) && fits(lsl_q, ord_q - 1'b1, size_q);
		stat.head_end      = (head_cur == END_MARK);
		stat.at_top        = (ord_q >= m_eff);
		stat.range_bad     = ((offset_q >> shamt) != '0) ||
			((offset_q & ((ADDR_W'(1) << lsl_q) - ADDR_W'(1))) != '0);
		stat.entry_ok      = (rd_next == BUSY_MARK) && (rd_order <= m_eff);
		stat.buddy_free    = (rd_next != BUSY_MARK) && (rd_order == ord_q);
		stat.head_is_buddy = (head_cur == {1'b0, buddy_q});
		stat.walk_stop     = (steps_q == (IW+1)'(TBL)) || (cur_q == END_MARK) ||
			(cur_q == BUSY_MARK);
		stat.link_hit      = (rd_next == {1'b0, buddy_q});
		stat.out_free      = !out_valid_q || out_ready;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = off_q;
		mem_raddr = off_q;
		mem_wdata = {head_cur, ord_q};
		case (op)
			OP_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = (sweep_q == '0) ? {END_MARK, m_eff} : '0;
			end
			OP_SPLIT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = off_q ^ ord_bit;
			end
			OP_A_GRANT: begin
				mem_we    = 1'b1;
				mem_wdata = {BUSY_MARK, ord_q};
			end
			OP_F_CLAIM: begin
				mem_we    = 1'b1;
				mem_waddr = local_q;
				mem_wdata = {END_MARK, rd_order};
			end
			OP_WALK_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = cidx_q;
				mem_wdata = {bnext_q, rd_order};
			end
			OP_PUSH: begin
				mem_we    = 1'b1;
				mem_waddr = local_q;
			end
			OP_A_READ: begin
				mem_re    = 1'b1;
				mem_raddr = head_cur[IW-1:0];
			end
			OP_F_READ: begin
				mem_re    = 1'b1;
				mem_raddr = local_calc;
			end
			OP_B_READ: begin
				mem_re    = 1'b1;
				mem_raddr = local_q ^ ord_bit;
			end
			OP_WALK_READ: begin
				mem_re    = 1'b1;
				mem_raddr = cur_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			full_q      <= 1'b0;
			sweep_q     <= '0;
			lsl_q       <= LSL_RST;
			maxo_q      <= MAXO_RST;
			base_q      <= BASE_RST;
			for (int i = 0; i < HN; i++) heads_q[i] <= END_MARK;
		end else begin
			if (res_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (op)
				OP_SWEEP: begin
					if (sweep_last) begin
						for (int i = 0; i < HN; i++)
							heads_q[i] <= (i == int'(m_eff)) ? '0 : END_MARK;
					end
				end
				OP_A_POP:       heads_q[hsel] <= rd_next;
				OP_SPLIT_WR:    heads_q[hsel] <= NW'(off_q ^ ord_bit);
				OP_UNLINK_HEAD: heads_q[hsel] <= rd_next;
				OP_PUSH:        heads_q[hsel] <= NW'(local_q);
				default: ;
			endcase
			// a config write to a defined register restarts the full table clear
			if (cfg_valid) begin
				case (cfg_index)
					CFG_LEAF_LOG2: lsl_q  <= cfg_data[LSL_W-1:0];
					CFG_MAX_ORDER: maxo_q <= cfg_data[ORD_W-1:0];
					CFG_POOL_BASE: base_q <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_hit) begin
				full_q  <= 1'b1;
				sweep_q <= '0;
			end else if (op == OP_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				opc_q   <= opcode;
				size_q  <= request_size;
				faddr_q <= free_address;
				ord_q   <= '0;
			end
			OP_SCAN_INC:  ord_q <= ord_q + 1'b1;
			OP_A_READ:    off_q <= head_cur[IW-1:0];
			OP_SPLIT_DEC: ord_q <= ord_q - 1'b1;
			OP_A_GRANT: begin
				res_stat_q <= ST_OK;
				res_addr_q <= grant_addr;
				res_ord_q  <= ord_q;
			end
			OP_OOM: begin
				res_stat_q <= ST_OOM;
				res_addr_q <= '0;
				res_ord_q  <= '0;
			end
			OP_BAD: begin
				res_stat_q <= ST_BAD;
				res_addr_q <= '0;
				res_ord_q  <= '0;
			end
			OP_NULL: begin
				res_stat_q <= ST_OK;
				res_addr_q <= '0;
				res_ord_q  <= '0;
			end
			OP_F_SUB:   offset_q <= faddr_q - base_q;
			OP_F_READ:  local_q  <= local_calc;
			OP_F_CLAIM: ord_q    <= rd_order;
			OP_B_READ:  buddy_q  <= local_q ^ ord_bit;
			OP_UNLINK_HEAD, OP_WALK_LINK: begin
				ord_q   <= ord_q + 1'b1;
				local_q <= local_q & buddy_q;
			end
			OP_WALK_START: begin
				bnext_q <= rd_next;
				cur_q   <= head_cur;
				steps_q <= '0;
			end
			OP_WALK_READ: begin
				cidx_q  <= cur_q[IW-1:0];
				steps_q <= steps_q + 1'b1;
			end
			OP_WALK_NEXT: cur_q <= rd_next;
			OP_PUSH: begin
				res_stat_q <= ST_OK;
				res_addr_q <= '0;
				res_ord_q  <= ord_q;
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = res_stat_q;
	assign block_address = res_addr_q;
	assign block_order   = res_ord_q;

endmodule

FILE: sv/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: at most one datapath operation per cycle for allocate, free and clear.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_op_t   op
);
	import bba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:     if (stat.sweep_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid) state_d = S_DISP;
			S_DISP: begin
				if (!stat.is_free)       state_d = S_A_SCAN;
				else if (stat.null_free) state_d = S_NULL;
				else                     state_d = S_F_SUB;
			end
			S_A_SCAN: begin
				if (stat.at_top || (stat.fit_cur && !stat.head_end)) begin
					if (!stat.fit_cur || stat.head_end) state_d = S_OOM;
					else                                state_d = S_A_POP;
				end
			end
			S_A_POP:    state_d = S_SPLIT;
			S_SPLIT:    state_d = stat.fit_low ? S_SPLIT_WR : S_GRANT;
			S_SPLIT_WR: state_d = S_SPLIT;
			S_GRANT, S_OOM, S_NULL, S_BAD, S_PUSH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_F_SUB:    state_d = S_F_CHK;
			S_F_CHK:    state_d = stat.range_bad ? S_BAD : S_F_VAL;
			S_F_VAL:    state_d = stat.entry_ok ? S_MERGE : S_BAD;
			S_MERGE:    state_d = stat.at_top ? S_PUSH : S_BCHK;
			S_BCHK: begin
				if (!stat.buddy_free)        state_d = S_PUSH;
				else if (stat.head_is_buddy) state_d = S_MERGE;
				else                         state_d = S_WALK;
			end
			S_WALK:     state_d = stat.walk_stop ? S_PUSH : S_WCHK;
			S_WCHK:     state_d = stat.link_hit ? S_MERGE : S_WALK;
			default:    state_d = S_INIT;
		endcase
		if (stat.cfg_hit) state_d = S_INIT;
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: op = OP_SWEEP;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_CAPTURE;
			end
			S_A_SCAN: begin
				if (!stat.at_top && (!stat.fit_cur || stat.head_end)) op = OP_SCAN_INC;
				else if (stat.fit_cur && !stat.head_end)              op = OP_A_READ;
			end
			S_A_POP:    op = OP_A_POP;
			S_SPLIT:    if (stat.fit_low) op = OP_SPLIT_DEC;
			S_SPLIT_WR: op = OP_SPLIT_WR;
			S_GRANT:    if (stat.out_free) op = OP_A_GRANT;
			S_OOM:      if (stat.out_free) op = OP_OOM;
			S_NULL:     if (stat.out_free) op = OP_NULL;
			S_BAD:      if (stat.out_free) op = OP_BAD;
			S_PUSH:     if (stat.out_free) op = OP_PUSH;
			S_F_SUB:    op = OP_F_SUB;
			S_F_CHK:    if (!stat.range_bad) op = OP_F_READ;
			S_F_VAL:    if (stat.entry_ok) op = OP_F_CLAIM;
			S_MERGE:    if (!stat.at_top) op = OP_B_READ;
			S_BCHK: begin
				if (stat.buddy_free) op = stat.head_is_buddy ? OP_UNLINK_HEAD : OP_WALK_START;
			end
			S_WALK:     if (!stat.walk_stop) op = OP_WALK_READ;
			S_WCHK:     op = stat.link_hit ? OP_WALK_LINK : OP_WALK_NEXT;
			default: ;
		endcase
	end

	// results only load into a free output word
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_A_GRANT || op == OP_OOM || op == OP_BAD || op == OP_NULL ||
		 op == OP_PUSH) |-> stat.out_free)
		else $error("result loaded over pending word");

	a_walk_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCHK) |-> ($past(op) == OP_WALK_READ))
		else $error("list check without read");

	a_split_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT_WR && !$past(stat.cfg_hit)) |-> ($past(op) == OP_SPLIT_DEC))
		else $error("split write without order step");

endmodule

FILE: sv/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator with per-order free lists over a leaf table memory.
// ----------------------------------------------------------------------------
// One request at a time through a single-port leaf table (one read or write per
// cycle). Allocate scans the orders up for a fitting non-empty list, pops its head
// and splits down; free checks the address, then merges level by level, walking a
// free list to unlink a buddy that is not its head. A result word waits in an
// output register so the next request is taken meanwhile. A config write to a
// defined register clears the 2^MAX_ORDER-entry table, one entry per cycle, before
// requests are taken; after reset only entry zero is set up. MAX_ORDER ranges 1..15.
module buddy_block_allocator_core #(
	parameter int MAX_ORDER = bba_pkg::MAX_ORDER_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bba_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic [bba_pkg::SIZE_W-1:0]     request_size,
	input  logic [bba_pkg::ADDR_W-1:0]     free_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bba_pkg::STAT_W-1:0]     status,
	output logic [bba_pkg::ADDR_W-1:0]     block_address,
	output logic [bba_pkg::ORD_W-1:0]      block_order
);
	import bba_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.op       (op)
	);

	bba_datapath #(
		.MAX_ORDER (MAX_ORDER)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.request_size  (request_size),
		.free_address  (free_address),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.block_address (block_address),
		.block_order   (block_order),
		.op            (op),
		.stat          (stat)
	);

endmodule

FILE: test/buddy_block_allocator_core_test.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_test
// Self-checking bench for the buddy allocator: an in-bench allocator model
// predicts every response word; directed corner cases, then register sweeps
// with random allocate/free traffic, random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_test;
	import bba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int                   TBL_N      = 1 << MAX_ORDER_DEF;
	localparam logic [31:0]          LINK_END   = 32'hFFFF_FFFF;
	localparam logic [31:0]          LINK_BUSY  = 32'hFFFF_FFFE;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
	localparam int                   IDLE_LIMIT = 12000;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [ADDR_W-1:0] addr;
		logic [ORD_W-1:0]  ord;
	} resp_t;

	logic                 clk, arst_n;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 in_valid, in_ready, opcode;
	logic [SIZE_W-1:0]    request_size;
	logic [ADDR_W-1:0]    free_address;
	logic                 out_valid, out_ready;
	logic [STAT_W-1:0]    status;
	logic [ADDR_W-1:0]    block_address;
	logic [ORD_W-1:0]     block_order;

	buddy_block_allocator_core u_dut (.*);

	// allocator model state
	logic [4:0]        leaf_log2;
	logic [3:0]        tree_height;
	logic [ADDR_W-1:0] base_addr;
	logic [31:0]       list_head [0:MAX_ORDER_DEF];
	logic [31:0]       leaf_next [0:TBL_N-1];
	logic [7:0]        leaf_ord  [0:TBL_N-1];

	resp_t             pending_q[$];
	logic [ADDR_W-1:0] held_blocks[$];
	logic [ADDR_W-1:0] released[$];
	int                errors;
	bit                idle_en, hold_req;
	int                quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int height();
		return (tree_height > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(tree_height);
	endfunction

	function automatic void rebuild_lists();
		int h;
		h = height();
		for (int i = 0; i <= MAX_ORDER_DEF; i++) list_head[i] = LINK_END;
		for (int i = 0; i < TBL_N; i++) begin
			leaf_next[i] = '0;
			leaf_ord[i]  = '0;
		end
		list_head[h] = '0;
		leaf_next[0] = LINK_END;
		leaf_ord[0]  = 8'(h);
		held_blocks.delete();
		released.delete();
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		case (idx)
			CFG_LEAF_LOG2: leaf_log2 = val[4:0];
			CFG_MAX_ORDER: tree_height = val[3:0];
			CFG_POOL_BASE: base_addr = val;
			default: return;
		endcase
		rebuild_lists();
	endfunction

	function automatic resp_t grant_block(logic [63:0] size);
		resp_t r;
		int h, ord;
		logic [63:0] bsz;
		int off, bud;
		r = '0;
		h = height();
		ord = 0;
		bsz = 64'd1 << leaf_log2;
		while (ord < h && (bsz < size || list_head[ord] == LINK_END)) begin
			ord++;
			bsz <<= 1;
		end
		if (bsz < size || list_head[ord] == LINK_END) begin
			r.st = ST_OOM;
			return r;
		end
		off = int'(list_head[ord] & (TBL_N - 1));
		list_head[ord] = leaf_next[off];
		while (ord > 0 && (bsz >> 1) >= size) begin
			bud = (off ^ (1 << (ord - 1))) & (TBL_N - 1);
			ord--;
			bsz >>= 1;
			leaf_next[bud] = list_head[ord];
			leaf_ord[bud]  = 8'(ord);
			list_head[ord] = 32'(bud);
		end
		leaf_next[off] = LINK_BUSY;
		leaf_ord[off]  = 8'(ord);
		r.st   = ST_OK;
		r.addr = base_addr + ADDR_W'(64'(off) << leaf_log2);
		r.ord  = ORD_W'(ord);
		return r;
	endfunction

	function automatic bit drop_from_list(int ord, logic [31:0] blk);
		logic [31:0] cur;
		cur = list_head[ord];
		if (cur == blk) begin
			list_head[ord] = leaf_next[blk];
			return 1'b1;
		end
		for (int s = 0; s < TBL_N; s++) begin
			if (cur == LINK_END || cur == LINK_BUSY) return 1'b0;
			cur &= TBL_N - 1;
			if (leaf_next[cur] == blk) begin
				leaf_next[cur] = leaf_next[blk];
				return 1'b1;
			end
			cur = leaf_next[cur];
		end
		return 1'b0;
	endfunction

	function automatic resp_t release_block(logic [ADDR_W-1:0] addr);
		resp_t r;
		int h, d, loc, bud;
		logic [63:0] off;
		r = '0;
		if (addr == '0) return r;
		h = height();
		off = 64'(ADDR_W'(addr - base_addr));
		if (off >= (64'd1 << (leaf_log2 + h)) || (off & ((64'd1 << leaf_log2) - 1)) != 0) begin
			r.st = ST_BAD;
			return r;
		end
		loc = int'((off >> leaf_log2) & (TBL_N - 1));
		if (leaf_next[loc] != LINK_BUSY || leaf_ord[loc] > h) begin
			r.st = ST_BAD;
			return r;
		end
		d = int'(leaf_ord[loc]);
		leaf_next[loc] = LINK_END;
		while (d < h) begin
			bud = (loc ^ (1 << d)) & (TBL_N - 1);
			if (leaf_next[bud] == LINK_BUSY || leaf_ord[bud] != d) break;
			if (!drop_from_list(d, 32'(bud))) break;
			d++;
			loc &= bud;
		end
		leaf_ord[loc]  = 8'(d);
		leaf_next[loc] = list_head[d];
		list_head[d]   = 32'(loc);
		r.ord = ORD_W'(d);
		return r;
	endfunction

	// ---- driving

	task automatic send_word(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		resp_t r;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		opcode       <= op;
		request_size <= size;
		free_address <= addr;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OPC_ALLOC) begin
			r = grant_block(64'(size));
			if (r.st == ST_OK) held_blocks.push_back(r.addr);
		end else begin
			r = release_block(addr);
			if (r.st == ST_OK && addr != '0) begin
				foreach (held_blocks[i])
					if (held_blocks[i] == addr) begin
						held_blocks.delete(i);
						break;
					end
				released.push_back(addr);
				if (released.size() > 8) void'(released.pop_front());
			end
		end
		pending_q.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_register(idx, val);
	endtask

	task automatic set_pool(int lg, int ht, logic [ADDR_W-1:0] base);
		drain();
		write_register(CFG_LEAF_LOG2, ADDR_W'(lg));
		write_register(CFG_MAX_ORDER, ADDR_W'(ht));
		write_register(CFG_POOL_BASE, base);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		int k, h;
		logic [63:0] lo, span, v;
		h = height();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: begin
				k = $urandom_range(0, h + 1);
				lo = (k == 0) ? 64'd0 : (64'd1 << (leaf_log2 + k - 1));
				span = (64'd1 << (leaf_log2 + k)) - lo;
				v = lo + ({$urandom, $urandom} % span) + 1;
				return (v > 64'hFFFF_FFFF) ? '1 : v[31:0];
			end
		endcase
	endfunction

	task automatic random_traffic(int n);
		int sel;
		logic [ADDR_W-1:0] a;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (held_blocks.size() != 0 && sel < 42) begin
				send_word(OPC_FREE, $urandom, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
			end else if (sel < 50) begin
				case ($urandom_range(0, 4))
					0: a = '0;
					1: a = ADDR_W'({$urandom, $urandom});
					2: a = (released.size() != 0) ?
						released[$urandom_range(0, released.size() - 1)] : '1;
					3: a = base_addr + ADDR_W'($urandom_range(1, 3));
					default: a = base_addr + ADDR_W'(64'd1 << (leaf_log2 + height()));
				endcase
				send_word(OPC_FREE, $urandom, a);
			end else begin
				send_word(OPC_ALLOC, pick_size(), ADDR_W'({$urandom, $urandom}));
			end
		end
	endtask

	// ---- tests

	task automatic test_directed();
		logic [ADDR_W-1:0] a0, a1;
		send_word(OPC_ALLOC, 32'd0, '0);
		a0 = held_blocks[$];
		send_word(OPC_ALLOC, 32'd1, '1);
		a1 = held_blocks[$];
		send_word(OPC_ALLOC, 32'd16, '0);
		send_word(OPC_ALLOC, 32'd17, '0);
		send_word(OPC_ALLOC, 32'hFFFF_FFFF, '0);
		send_word(OPC_ALLOC, 32'd16384, '0);          // pool fragmented: no room
		send_word(OPC_FREE, '1, '0);                  // null free
		send_word(OPC_FREE, '0, a0 + 48'd1);          // misaligned
		send_word(OPC_FREE, '0, BASE_RST + 48'd16384); // beyond the pool
		send_word(OPC_FREE, '0, 48'hFFFF_FFFF_FFFF);
		send_word(OPC_FREE, '0, BASE_RST + 48'd48);   // free leaf, never granted
		send_word(OPC_FREE, '0, a0);
		send_word(OPC_FREE, '0, a0);                  // double free
		while (held_blocks.size() != 0) send_word(OPC_FREE, '0, held_blocks[0]);
		send_word(OPC_FREE, '0, a1);
		send_word(OPC_ALLOC, 32'd16384, '0);          // whole pool
		send_word(OPC_ALLOC, 32'd0, '0);
		send_word(OPC_FREE, '0, held_blocks[0]);
	endtask

	task automatic test_register_sweep();
		set_pool(1, 0, 48'd1);
		random_traffic(40);
		set_pool(20, 10, 48'hFFFF_FFF0_0000);         // pool wraps past the top
		random_traffic(110);
		drain();
		write_register(CFG_SPARE, '1);
		random_traffic(40);
		set_pool(31, 15, '0);
		random_traffic(80);
		set_pool(3, 3, ADDR_W'({$urandom, $urandom}));
		random_traffic(110);
		set_pool(2, 6, ADDR_W'({$urandom, $urandom}) | 48'd1);
		random_traffic(120);
	endtask

	task automatic test_output_hold();
		set_pool(4, 10, BASE_RST);
		hold_req = 1'b1;
		random_traffic(30);
	endtask

	task automatic test_full_rate();
		drain();
		idle_en = 1'b0;
		random_traffic(180);
	endtask

	// ---- response side

	int hold_left, gap_left;
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		resp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("response word with nothing pending");
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status);
					errors++;
				end
				if (block_address !== e.addr) begin
					$error("block_address exp %h got %h", e.addr, block_address);
					errors++;
				end
				if (block_order !== e.ord) begin
					$error("block_order exp %0d got %0d", e.ord, block_order);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OPC_ALLOC;
		request_size = '0;
		free_address = '0;
		errors = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		idle_en = 1'b1;
		leaf_log2 = LSL_RST;
		tree_height = MAXO_RST;
		base_addr = BASE_RST;
		rebuild_lists();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_sweep();
		test_output_hold();
		test_full_rate();
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
sv/bba_pkg.sv
sv/bba_datapath.sv
sv/bba_ctrl.sv
sv/buddy_block_allocator_core.sv
test/buddy_block_allocator_core_test.sv
